// ----- rtl/its_pkg.sv -----
// Shared types and constants for the I2C transfer sequencer.
// Holds the request and result payload structs, phase codes and result codes.
// No dependencies.
package its_pkg;

  // Transfer phase codes.
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_ADDR = 2'd1;
  localparam logic [1:0] PH_DATA = 2'd2;
  localparam logic [1:0] PH_STOP = 2'd3;

  // Result codes handed back with every poll.
  localparam logic [2:0] RC_AGAIN  = 3'd0;
  localparam logic [2:0] RC_MOVED  = 3'd1;
  localparam logic [2:0] RC_DONE   = 3'd2;
  localparam logic [2:0] RC_NACKED = 3'd3;
  localparam logic [2:0] RC_BADLEN = 3'd4;

  // Operation codes.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // Transfer modes.
  localparam logic MODE_MASTER = 1'b0;
  localparam logic MODE_SLAVE  = 1'b1;

  // Configuration register indexes.
  localparam logic REG_MODE = 1'b0;
  localparam logic REG_ADDR = 1'b1;

  // One poll request.
  typedef struct packed {
    logic        operation;
    logic [15:0] bytes_left;
    logic [7:0]  tx_byte;
    logic [7:0]  rx_byte;
    logic        ack_missing;
    logic        transmit_busy;
    logic        receive_full;
    logic        transmit_full;
    logic        data_phase;
    logic        read_direction;
    logic [2:0]  control_busy;
  } item_t;

  // One poll result.
  typedef struct packed {
    logic [2:0] result_code;
    logic       start_cmd;
    logic       stop_cmd;
    logic       load_tx;
    logic [7:0] tx_value;
    logic       receive_cmd;
    logic       nack_cmd;
    logic       release_clock;
    logic       pop_receive;
    logic [7:0] read_data;
    logic       data_valid;
  } result_t;

  // Configuration as seen by the sequencing logic.
  typedef struct packed {
    logic       transfer_mode;
    logic [6:0] target_address;
  } cfg_t;

endpackage

// ----- rtl/its_if.sv -----
// Valid/ready channel interfaces for poll requests and poll results.
// Depends on its_pkg for the payload types.
interface its_in_if;
  logic            valid;
  logic            ready;
  its_pkg::item_t  item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface its_out_if;
  logic              valid;
  logic              ready;
  its_pkg::result_t  res;

  modport source (output valid, output res, input ready);
  modport sink   (input valid, input res, output ready);
endinterface

// ----- rtl/its_regs.sv -----
// APB-style configuration registers: transfer mode and target address.
// Depends on its_pkg for register indexes and the config struct.
module its_regs (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output its_pkg::cfg_t      cfg
);

  logic       mode_r;
  logic [6:0] addr_r;
  logic       wr_en;
  logic       reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[2];

  // Register writes complete in the access phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= its_pkg::MODE_SLAVE;
      addr_r <= 7'd0;
    end else if (wr_en) begin
      if (reg_sel == its_pkg::REG_MODE) begin
        mode_r <= pwdata[0];
      end else begin
        addr_r <= pwdata[6:0];
      end
    end
  end

  // Read back the selected register.
  always_comb begin
    if (reg_sel == its_pkg::REG_MODE) begin
      prdata = {31'd0, mode_r};
    end else begin
      prdata = {25'd0, addr_r};
    end
  end

  assign cfg.transfer_mode  = mode_r;
  assign cfg.target_address = addr_r;

endmodule

// ----- rtl/its_core.sv -----
// Per-poll decision logic and the transfer phase / last-byte state.
// Depends on its_pkg for codes and payload types.
module its_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  its_pkg::item_t    item,
  input  its_pkg::cfg_t     cfg,
  output its_pkg::result_t  res,
  output logic [1:0]        phase
);

  logic [1:0] phase_r, phase_nxt;
  logic       last_r, last_nxt;
  logic       n_zero, n_one, n_two;
  logic       rd;
  logic [7:0] addr_byte;

  assign n_zero    = (item.bytes_left == 16'd0);
  assign n_one     = (item.bytes_left == 16'd1);
  assign n_two     = (item.bytes_left == 16'd2);
  assign rd        = (item.operation == its_pkg::OP_READ);
  assign addr_byte = {cfg.target_address, 1'b0};
  assign phase     = phase_r;

  // Decide the commands for this poll and the next state.
  always_comb begin
    res             = '0;
    res.result_code = its_pkg::RC_AGAIN;
    phase_nxt       = phase_r;
    last_nxt        = last_r;
    if (n_zero) begin
      res.result_code = its_pkg::RC_BADLEN;
    end else if (cfg.transfer_mode == its_pkg::MODE_MASTER) begin
      unique case (phase_r)
        its_pkg::PH_IDLE: begin
          if (!item.control_busy[1]) begin
            res.start_cmd = 1'b1;
            phase_nxt     = its_pkg::PH_ADDR;
            last_nxt      = 1'b0;
          end
        end
        its_pkg::PH_STOP: begin
          if (!item.transmit_busy && item.control_busy == 3'd0) begin
            res.stop_cmd    = 1'b1;
            phase_nxt       = its_pkg::PH_IDLE;
            res.result_code = last_r ? its_pkg::RC_DONE : its_pkg::RC_NACKED;
          end
        end
        its_pkg::PH_ADDR: begin
          // Send the address with the direction bit once the start is out.
          if (!item.control_busy[0]) begin
            res.load_tx = 1'b1;
            if (rd) begin
              res.receive_cmd = 1'b1;
              res.tx_value    = addr_byte | 8'd1;
              res.nack_cmd    = n_one;
            end else begin
              res.tx_value = addr_byte;
            end
            phase_nxt = its_pkg::PH_DATA;
          end
        end
        default: begin
          if (rd) begin
            // Master read: collect the byte, NACK ahead of the last one.
            if (item.receive_full) begin
              res.nack_cmd    = n_two;
              res.pop_receive = 1'b1;
              res.read_data   = item.rx_byte;
              res.data_valid  = 1'b1;
              if (n_one) begin
                last_nxt  = 1'b1;
                phase_nxt = its_pkg::PH_STOP;
              end else begin
                res.receive_cmd = 1'b1;
                res.result_code = its_pkg::RC_MOVED;
              end
            end
          end else if (item.ack_missing) begin
            phase_nxt = its_pkg::PH_STOP;
          end else if (!item.transmit_busy) begin
            // Master write: push the next data byte.
            res.load_tx  = 1'b1;
            res.tx_value = item.tx_byte;
            if (n_one) begin
              last_nxt  = 1'b1;
              phase_nxt = its_pkg::PH_STOP;
            end else begin
              res.result_code = its_pkg::RC_MOVED;
            end
          end
        end
      endcase
    end else if (rd) begin
      // Slave receive: address bytes are dropped, data bytes delivered.
      if (item.receive_full) begin
        res.pop_receive   = 1'b1;
        res.release_clock = 1'b1;
        if (item.data_phase) begin
          res.read_data   = item.rx_byte;
          res.data_valid  = 1'b1;
          res.result_code = its_pkg::RC_MOVED;
        end
      end
    end else if (phase_r == its_pkg::PH_DATA) begin
      // Slave transmit: load the byte and release the stretched clock.
      if (!item.transmit_busy && !item.transmit_full) begin
        res.load_tx       = 1'b1;
        res.tx_value      = item.tx_byte;
        res.release_clock = 1'b1;
        res.result_code   = its_pkg::RC_MOVED;
        if (n_one) begin
          phase_nxt = its_pkg::PH_IDLE;
        end
      end
    end else if (!item.data_phase && item.read_direction) begin
      // Addressed for a read: drop the address byte and start sending.
      res.pop_receive = 1'b1;
      phase_nxt       = its_pkg::PH_DATA;
    end
  end

  // State advances only when a poll is evaluated.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= its_pkg::PH_IDLE;
      last_r  <= 1'b0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      last_r  <= last_nxt;
    end
  end

endmodule

// ----- rtl/i2c_transfer_sequencer_unit.sv -----
// Top level of the I2C transfer sequencer: input register, decision core, result register.
// Depends on its_pkg, its_if, its_regs and its_core.
//
// Usage: each request on in_chan is one write or read poll of the I2C controller,
// carrying the byte count, the bytes and a snapshot of the status flags. For each
// request exactly one result leaves on out_chan with the controller commands, a
// delivered byte and a result code. Both channels accept on valid and ready high.
// The configuration port sets master/slave mode and the partner address; the user
// must write it only while no request is in flight; the block does not enforce this.
// A request accepted on in_chan is registered in the input register, evaluated by
// the core and its result registered in the result register before it shows on out_chan.
// Throughput: one request per cycle while out_chan does not stall, set by the combinational
// decision between the input and result registers, which also updates the phase.
// Reset (synchronous, active low) empties both registers, returns to idle phase,
// slave mode and address zero. When out_chan stalls, the result register holds,
// the input register fills, and in_chan ready drops once both are occupied.
module i2c_transfer_sequencer_unit (
  input  logic          clk,
  input  logic          rst_n,
  its_in_if.sink        in_chan,
  its_out_if.source     out_chan,
  input  logic          cfg_psel,
  input  logic          cfg_penable,
  input  logic          cfg_pwrite,
  input  logic [2:0]    cfg_paddr,
  input  logic [31:0]   cfg_pwdata,
  output logic [31:0]   cfg_prdata,
  output logic          cfg_pready
);

  its_pkg::item_t    item_r;
  logic              item_v_r;
  its_pkg::result_t  res_r;
  logic              res_v_r;
  its_pkg::result_t  res_nxt;
  its_pkg::cfg_t     cfg;
  logic [1:0]        phase;
  logic              res_room;
  logic              fire;
  logic              in_fire;

  its_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // Pipeline handshake: the result register frees up when it is empty or taken.
  assign res_room      = !res_v_r || out_chan.ready;
  assign fire          = item_v_r && res_room;
  assign in_chan.ready = !item_v_r || res_room;
  assign in_fire       = in_chan.valid && in_chan.ready;

  its_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (item_r),
    .cfg   (cfg),
    .res   (res_nxt),
    .phase (phase)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
    end else if (in_chan.ready) begin
      item_v_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r <= in_chan.item;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_v_r <= 1'b0;
    end else if (res_room) begin
      res_v_r <= item_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_chan.valid = res_v_r;
  assign out_chan.res   = res_r;

`ifndef ASSERT_OFF
  // A bad-length result never carries a controller command.
  assert property (@(posedge clk) disable iff (!rst_n)
    (res_v_r && res_r.result_code == its_pkg::RC_BADLEN) |->
      !(res_r.start_cmd || res_r.stop_cmd || res_r.load_tx || res_r.receive_cmd ||
        res_r.pop_receive || res_r.release_clock))
    else $error("command issued with bad length result");

  // Unused byte fields are zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    res_v_r |-> ((res_r.data_valid || res_r.read_data == 8'd0) &&
                 (res_r.load_tx || res_r.tx_value == 8'd0)))
    else $error("stale byte in result");

  // A stop result always returns the core to idle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (fire && res_nxt.stop_cmd) |=> (phase == its_pkg::PH_IDLE))
    else $error("stop issued without returning to idle");

  // A stalled result register blocks the decision stage.
  assert property (@(posedge clk) disable iff (!rst_n)
    (res_v_r && !out_chan.ready) |-> !fire)
    else $error("result overwritten while stalled");
`endif

endmodule
